### design/bpc_pkg.sv
// shared types and constants for the button press classifier
`default_nettype none
package bpc_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 8;

  localparam logic [CfgW-1:0] DebounceRst = 16'd50;
  localparam logic [CfgW-1:0] LongRst     = 16'd1500;
  localparam logic [CfgW-1:0] WindowRst   = 16'd300;

  typedef enum logic [CfgIdxW-1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_LONG     = 2'd1,
    REG_WINDOW   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_SINGLE = 2'd1,
    KIND_DOUBLE = 2'd2,
    KIND_LONG   = 2'd3
  } kind_t;

  typedef struct packed {
    logic             pin_level;
    logic [TimeW-1:0] time_ms;
  } sample_t;

  typedef struct packed {
    logic            wr;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0] data;
  } cfg_wr_t;

endpackage
`default_nettype wire

### design/bpc_in_stage.sv
// input register stage holding one sample word
`default_nettype none
module bpc_in_stage (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  wire  [bpc_pkg::InDataW-1:0] in_tdata,
  input  wire                      advance,
  output logic                     s1_valid,
  output bpc_pkg::sample_t         s1_sample
);
  import bpc_pkg::*;

  logic    valid_r, valid_nxt;
  sample_t sample_r;

  assign in_tready = !valid_r || advance;
  assign valid_nxt = (in_tvalid && in_tready) || (valid_r && !advance);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      sample_r.pin_level <= in_tdata[0];
      sample_r.time_ms   <= in_tdata[TimeW:1];
    end
  end

  assign s1_valid  = valid_r;
  assign s1_sample = sample_r;
endmodule
`default_nettype wire

### design/bpc_core.sv
// press state, settings registers and the classification logic
`default_nettype none
module bpc_core (
  input  wire               clk,
  input  wire               rst_n,
  input  bpc_pkg::cfg_wr_t  cfg,
  input  wire               fire,
  input  bpc_pkg::sample_t  sample,
  output bpc_pkg::kind_t    kind
);
  import bpc_pkg::*;

  logic [CfgW-1:0]  debounce_r, long_r, window_r;
  logic             prev_level_r, prev_level_nxt;
  logic [TimeW-1:0] change_time_r, change_time_nxt;
  logic             is_held_r, is_held_nxt;
  logic [TimeW-1:0] hold_start_r, hold_start_nxt;
  logic [TimeW-1:0] release_time_r, release_time_nxt;
  logic [1:0]       release_count_r, release_count_nxt;
  logic             long_rep_r, long_rep_nxt;

  logic             level;
  logic [TimeW-1:0] now, since_change, since_hold, since_release;
  logic             press_start, long_hit, release_hit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r <= DebounceRst;
      long_r     <= LongRst;
      window_r   <= WindowRst;
    end else if (cfg.wr) begin
      case (cfg.idx)
        REG_DEBOUNCE: debounce_r <= cfg.data;
        REG_LONG:     long_r     <= cfg.data;
        REG_WINDOW:   window_r   <= cfg.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    level = sample.pin_level;
    now   = sample.time_ms;
    kind  = KIND_NONE;

    prev_level_nxt    = level;
    change_time_nxt   = (level != prev_level_r) ? now : change_time_r;
    is_held_nxt       = is_held_r;
    hold_start_nxt    = hold_start_r;
    release_time_nxt  = release_time_r;
    release_count_nxt = release_count_r;
    long_rep_nxt      = long_rep_r;

    since_change = now - change_time_nxt;
    press_start  = 1'b0;
    long_hit     = 1'b0;
    release_hit  = 1'b0;
    since_hold   = '0;
    since_release = '0;

    if (since_change >= {{(TimeW-CfgW){1'b0}}, debounce_r}) begin
      press_start = !level && !is_held_r;
      if (press_start) begin
        is_held_nxt    = 1'b1;
        hold_start_nxt = now;
        long_rep_nxt   = 1'b0;
      end
      since_hold = now - hold_start_nxt;
      long_hit   = is_held_nxt && !level && !long_rep_nxt &&
                   (since_hold >= {{(TimeW-CfgW){1'b0}}, long_r});
      if (long_hit) begin
        long_rep_nxt      = 1'b1;
        release_count_nxt = 2'd0;
        kind              = KIND_LONG;
      end
      release_hit = level && is_held_nxt;
      if (release_hit) begin
        is_held_nxt = 1'b0;
        if (!long_rep_nxt) begin
          if (release_count_nxt != 2'd3) begin
            release_count_nxt = release_count_nxt + 2'd1;
          end
          release_time_nxt = now;
        end
      end
      since_release = now - release_time_nxt;
      if ((release_count_nxt != 2'd0) && !is_held_nxt &&
          (since_release >= {{(TimeW-CfgW){1'b0}}, window_r})) begin
        kind              = (release_count_nxt >= 2'd2) ? KIND_DOUBLE : KIND_SINGLE;
        release_count_nxt = 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_level_r    <= 1'b1;
      change_time_r   <= '0;
      is_held_r       <= 1'b0;
      hold_start_r    <= '0;
      release_time_r  <= '0;
      release_count_r <= 2'd0;
      long_rep_r      <= 1'b0;
    end else if (fire) begin
      prev_level_r    <= prev_level_nxt;
      change_time_r   <= change_time_nxt;
      is_held_r       <= is_held_nxt;
      hold_start_r    <= hold_start_nxt;
      release_time_r  <= release_time_nxt;
      release_count_r <= release_count_nxt;
      long_rep_r      <= long_rep_nxt;
    end
  end
endmodule
`default_nettype wire

### design/bpc_out_reg.sv
// result register feeding the output stream
`default_nettype none
module bpc_out_reg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          fire,
  input  bpc_pkg::kind_t               kind,
  output logic                         advance,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [bpc_pkg::OutDataW-1:0] out_tdata
);
  import bpc_pkg::*;

  logic  valid_r, valid_nxt;
  kind_t kind_r;

  assign advance   = !valid_r || out_tready;
  assign valid_nxt = fire || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      kind_r <= kind;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {{(OutDataW-2){1'b0}}, kind_r};
endmodule
`default_nettype wire

### design/button_press_classifier.sv
// top level of the debounced single, double and long press classifier
//
//  channel | direction | word
//  in_     | slave     | tdata[0] pin_level, tdata[32:1] time_ms, tdata[39:33] zero
//  out_    | master    | tdata[1:0] press_kind, tdata[7:2] zero
//  cfg_    | slave     | cfg_index register, cfg_data 16-bit value
//
// one word per cycle while the output is not stalled; a sample enters the input
// register, and its result is then registered in the output register
// the state update is a single pass of compares and subtractions on 32 bits
// synchronous reset restores the press state and the default settings
// a stalled output holds the pipe; the input register still takes a word
// while the output register drains
`default_nettype none
module button_press_classifier (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [bpc_pkg::InDataW-1:0]  in_tdata,   // pin_level, time_ms
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [bpc_pkg::OutDataW-1:0] out_tdata,  // press_kind
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [bpc_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire  [bpc_pkg::CfgW-1:0]     cfg_data
);
  import bpc_pkg::*;

  logic    advance, s1_valid, fire;
  sample_t s1_sample;
  kind_t   kind;
  cfg_wr_t cfg;

  assign cfg_ready = 1'b1;
  assign cfg.wr    = cfg_valid && cfg_ready;
  assign cfg.idx   = cfg_index;
  assign cfg.data  = cfg_data;
  assign fire      = s1_valid && advance;

  bpc_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .advance   (advance),
    .s1_valid  (s1_valid),
    .s1_sample (s1_sample)
  );

  bpc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg),
    .fire   (fire),
    .sample (s1_sample),
    .kind   (kind)
  );

  bpc_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .kind       (kind),
    .advance    (advance),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output register");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> s1_valid)
    else $error("accepted word missing from input register");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("result lost after classification");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !s1_valid)
    else $error("pipeline not empty after reset");
endmodule
`default_nettype wire

### tb/sv/button_press_classifier_tb.sv
// self-checking testbench for the button press classifier
`timescale 1ns / 100ps
module button_press_classifier_tb;
  import bpc_pkg::*;

  localparam int CycleLimit = 1500000;
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [InDataW-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0] cfg_data = '0;

  // own copy of the settings and the press state
  logic [CfgW-1:0] deb_ms = DebounceRst;
  logic [CfgW-1:0] long_ms = LongRst;
  logic [CfgW-1:0] window_ms = WindowRst;
  logic seen_level = 1'b1;
  logic [TimeW-1:0] level_since = '0;
  logic holding = 1'b0;
  logic [TimeW-1:0] hold_from = '0;
  logic [TimeW-1:0] released_at = '0;
  logic [1:0] release_tally = '0;
  logic long_sent = 1'b0;

  kind_t expected_kinds[$];
  logic [TimeW-1:0] stim_time = '0;
  logic calm = 1'b0;
  int items_sent = 0;
  int fail_count = 0;
  int cycle_count = 0;
  int ready_left = 0;

  button_press_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // pin_level, time_ms
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // press_kind
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic logic [TimeW-1:0] ms_since(logic [TimeW-1:0] from, logic [TimeW-1:0] now);
    return now - from;
  endfunction

  function automatic kind_t next_press_kind(logic lvl, logic [TimeW-1:0] now);
    kind_t kind;
    kind = KIND_NONE;
    if (lvl != seen_level) begin
      level_since = now;
    end
    if (ms_since(level_since, now) < {16'd0, deb_ms}) begin
      seen_level = lvl;
      return KIND_NONE;
    end
    if (!lvl && !holding) begin
      holding = 1'b1;
      hold_from = now;
      long_sent = 1'b0;
    end
    if (holding && !lvl && !long_sent && ms_since(hold_from, now) >= {16'd0, long_ms}) begin
      long_sent = 1'b1;
      release_tally = '0;
      kind = KIND_LONG;
    end
    if (lvl && holding) begin
      holding = 1'b0;
      if (!long_sent) begin
        if (release_tally != 2'd3) begin
          release_tally = release_tally + 2'd1;
        end
        released_at = now;
      end
    end
    if (release_tally != 2'd0 && !holding &&
        ms_since(released_at, now) >= {16'd0, window_ms}) begin
      kind = (release_tally >= 2'd2) ? KIND_DOUBLE : KIND_SINGLE;
      release_tally = '0;
    end
    seen_level = lvl;
    return kind;
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // time step clustered around a threshold
  function automatic logic [TimeW-1:0] step_near(logic [CfgW-1:0] th);
    int unsigned r;
    int unsigned base;
    base = 32'(th);
    r = $urandom_range(0, 19);
    if (r < 3) begin
      return base;
    end else if (r < 5) begin
      return base + 1;
    end else if (r < 7) begin
      return (base == 0) ? 0 : base - 1;
    end else if (r < 15) begin
      return $urandom_range(0, base);
    end else if (r < 19) begin
      return base + $urandom_range(0, base);
    end
    return $urandom;
  endfunction

  task automatic send_sample(logic lvl, logic [TimeW-1:0] t);
    int gap;
    in_tdata <= {{(InDataW-TimeW-1){1'b0}}, t, lvl};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expected_kinds.push_back(next_press_kind(lvl, t));
    items_sent++;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DEBOUNCE: deb_ms = val;
      REG_LONG:     long_ms = val;
      REG_WINDOW:   window_ms = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // stop sending and wait for every outstanding word
  task automatic settle();
    in_tvalid <= 1'b0;
    while (expected_kinds.size() > 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic set_timing(logic [CfgW-1:0] deb, logic [CfgW-1:0] lng, logic [CfgW-1:0] win);
    settle();
    write_reg(REG_DEBOUNCE, deb);
    write_reg(REG_LONG, lng);
    write_reg(REG_WINDOW, win);
    write_reg(RegSpare, 16'($urandom));
  endtask

  task automatic send_gesture();
    int m;
    int k;
    // press with contact bounce
    m = $urandom_range(0, 2);
    for (int i = 0; i < 2 * m + 1; i++) begin
      stim_time += $urandom_range(0, deb_ms);
      send_sample(1'(i % 2), stim_time);
    end
    stim_time += step_near(deb_ms);
    send_sample(1'b0, stim_time);
    k = $urandom_range(0, 3);
    repeat (k) begin
      stim_time += step_near(long_ms) >> $urandom_range(0, 2);
      send_sample(1'b0, stim_time);
    end
    // release with contact bounce
    m = $urandom_range(0, 2);
    for (int i = 0; i < 2 * m + 1; i++) begin
      stim_time += $urandom_range(0, deb_ms);
      send_sample(1'(1 - i % 2), stim_time);
    end
    stim_time += step_near(deb_ms);
    send_sample(1'b1, stim_time);
    k = $urandom_range(0, 2);
    repeat (k) begin
      stim_time += step_near(window_ms) >> $urandom_range(0, 1);
      send_sample(1'b1, stim_time);
    end
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: stim_time += step_near(deb_ms);
        1: stim_time += step_near(long_ms);
        2: stim_time += step_near(window_ms);
        default: stim_time += $urandom;
      endcase
      send_sample(1'($urandom_range(0, 1)), stim_time);
    end
  endtask

  task automatic test_default_settings();
    logic [TimeW-1:0] b;
    b = 32'hFFFF_FF00;
    // single press with bounce, across the timestamp wrap
    send_sample(1'b1, b);
    send_sample(1'b0, b + 100);
    send_sample(1'b1, b + 110);
    send_sample(1'b0, b + 120);
    send_sample(1'b0, b + 180);
    send_sample(1'b1, b + 300);
    send_sample(1'b1, b + 360);
    send_sample(1'b1, b + 700);
    // long hold, then a release that is not counted
    send_sample(1'b0, b + 800);
    send_sample(1'b0, b + 860);
    send_sample(1'b0, b + 2400);
    send_sample(1'b1, b + 2500);
    send_sample(1'b1, b + 2560);
    send_sample(1'b1, b + 3000);
  endtask

  task automatic test_zero_thresholds();
    set_timing(16'd0, 16'd0, 16'd0);
    send_sample(1'b0, 32'd0);
    send_sample(1'b1, 32'd1);
    settle();
    write_reg(REG_LONG, 16'hFFFF);
    send_sample(1'b0, 32'd2);
    send_sample(1'b1, 32'd3);
  endtask

  task automatic test_count_saturation();
    logic [TimeW-1:0] b;
    set_timing(16'd0, 16'hFFFF, 16'hFFFF);
    b = 32'hFFFF_FFF0;
    for (int i = 0; i < 4; i++) begin
      send_sample(1'b0, b + 2 * i);
      send_sample(1'b1, b + 2 * i + 1);
    end
    send_sample(1'b1, b + 7 + 65534);
    send_sample(1'b1, b + 7 + 65535);
  endtask

  task automatic test_random_timing();
    int target;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: set_timing(DebounceRst, LongRst, WindowRst);
        1: set_timing(16'd0, 16'd0, 16'd0);
        2: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: set_timing(16'd0, 16'($urandom_range(0, 2500)), 16'($urandom_range(0, 800)));
        7: set_timing(16'($urandom), 16'($urandom), 16'($urandom));
        default: set_timing(16'($urandom_range(0, 80)), 16'($urandom_range(0, 2500)),
                             16'($urandom_range(0, 800)));
      endcase
      calm = (p == 4);
      if ($urandom_range(0, 3) == 0) begin
        stim_time = 32'hFFFF_FFFF - $urandom_range(0, 200000);
      end else begin
        stim_time = $urandom;
      end
      target = items_sent + 210;
      while (items_sent < target) begin
        if ($urandom_range(0, 99) < 85) begin
          send_gesture();
        end else begin
          send_noise();
        end
      end
    end
    calm = 1'b0;
  endtask

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n || calm) begin
      out_tready <= 1'b1;
      ready_left = 0;
    end else if (ready_left > 0) begin
      ready_left--;
    end else if (out_tready) begin
      ready_left = pick_gap();
      if (ready_left > 0) begin
        out_tready <= 1'b0;
        ready_left--;
      end
    end else begin
      out_tready <= 1'b1;
      ready_left = $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin
    kind_t want;
    logic [1:0] got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[1:0];
      if (expected_kinds.size() == 0) begin
        $display("%0t: unexpected word, expected none, got kind %0d", $time, got);
        fail_count++;
      end else begin
        want = expected_kinds.pop_front();
        if (got !== want) begin
          $display("%0t: press_kind mismatch, expected %0d (%s), got %0d",
                   $time, want, want.name(), got);
          fail_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_default_settings();
    test_zero_thresholds();
    test_count_saturation();
    test_random_timing();
    settle();
    repeat (10) @(posedge clk);
    fail_count += expected_kinds.size();
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
